/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("lph assertion failed");

// Condition that must never be seen on an enabled clock edge.
`define ASSERT_NEVER(lbl, ck, rstn, cond) \
    `ASSERT_CLK(lbl, ck, rstn, !(cond))

`endif

/* rtl/lph_pkg.sv */
// Shared types, codes and constants of the linear probing hash table.
`default_nettype none

package lph_pkg;

    localparam int KEY_W    = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int SIZE_W   = 5;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Operation codes carried in the input tuser.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } lph_state_t;

endpackage

`default_nettype wire

/* rtl/lph_mod.sv */
// Iterative remainder unit: key modulo a small divisor, two quotient bits per cycle.
`default_nettype none

module lph_mod
    import lph_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [KEY_W-1:0]  dividend,
    input  wire logic [SIZE_W-1:0] divisor,
    output logic                   done,
    output logic [SIZE_W-1:0]      remainder
);

    localparam int MOD_STEPS = (KEY_W + 1) / 2;
    localparam int DIV_W     = 2 * MOD_STEPS;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    shift_reg, shift_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0]   div_reg, div_next;
    logic [SIZE_W:0]     trial_hi;
    logic [SIZE_W:0]     trial_lo;
    logic [SIZE_W-1:0]   rem_mid;
    logic [SIZE_W-1:0]   rem_step;
    logic                last_step;

    // Two restoring steps per cycle; the partial remainder stays below the divisor.
    always_comb
    begin
        trial_hi = {rem_reg, shift_reg[DIV_W-1]};
        if (trial_hi >= {1'b0, div_reg})
        begin
            rem_mid = SIZE_W'(trial_hi - {1'b0, div_reg});
        end
        else
        begin
            rem_mid = SIZE_W'(trial_hi);
        end
        trial_lo = {rem_mid, shift_reg[DIV_W-2]};
        if (trial_lo >= {1'b0, div_reg})
        begin
            rem_step = SIZE_W'(trial_lo - {1'b0, div_reg});
        end
        else
        begin
            rem_step = SIZE_W'(trial_lo);
        end
    end

    assign last_step = busy_reg && (cnt_reg == CNT_W'(MOD_STEPS - 1));
    assign done      = last_step;
    assign remainder = rem_step;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = DIV_W'(dividend);
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next   = cnt_reg + CNT_W'(1);
            shift_next = {shift_reg[DIV_W-3:0], 2'b00};
            rem_next   = rem_step;
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_table.sv */
// Top level of the linear probing hash table with its slot memory and sequencer.
//
// Open-addressing hash table over TABLE_DEPTH slots, of which clamped table_size are used.
// An item carries the operation in s_axis_tuser and the key in s_axis_tdata; every item
// gives exactly one result with a status and a slot. After reset the block clears the
// occupancy bits of the slot memory, one slot after another, and accepts no item
// then (configuration writes are always taken). An item is then hashed by the remainder
// unit, which retires two quotient bits per cycle, and then probes slots one after
// another, from 1 up to the live table size of them, each probe a read of the slot
// memory; its result is then loaded into the result register. An unused operation code
// skips hashing and probing. The result sits in an output register, so a new item can
// be taken while the previous result waits downstream.
// Write table_size only while the block is idle.
`default_nettype none

module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] key, [31] zero
    input  wire logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [1:0] status, [5:2] slot, [7:6] zero
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [SIZE_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;
    localparam int WORD_W = KEY_W + 1;
    localparam logic [SIZE_W-1:0] DEPTH_CAP =
        SIZE_W'((TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH);

    lph_state_t          state_reg, state_next;

    logic [SIZE_W-1:0]   table_size_reg;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [SIZE_W-1:0]   n_reg, n_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    // Slot memory: occupancy bit on top of the key.
    logic [WORD_W-1:0]   mem [TABLE_DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic                mod_start;
    logic                mod_done;
    logic [SIZE_W-1:0]   mod_rem;

    logic [SIZE_W-1:0]   live_size;
    logic [CMP_W-1:0]    pos_plus;
    logic [IDX_W-1:0]    pos_wrap;
    logic                probe_last;
    logic                slot_used;
    logic                key_hit;
    logic                in_xfer;

    lph_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (s_axis_tdata[KEY_W-1:0]),
        .divisor   (live_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_slot_reg, out_status_reg};

    // Clamp the configured size to 1..min(TABLE_DEPTH, 31).
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            live_size = SIZE_W'(1);
        end
        else if (table_size_reg > DEPTH_CAP)
        begin
            live_size = DEPTH_CAP;
        end
        else
        begin
            live_size = table_size_reg;
        end
    end

    assign pos_plus   = CMP_W'(pos_reg) + CMP_W'(1);
    assign pos_wrap   = (pos_plus == CMP_W'(size_reg)) ? '0 : IDX_W'(pos_plus);
    assign probe_last = (n_reg == SIZE_W'(size_reg - SIZE_W'(1)));
    assign slot_used  = rd_data_reg[KEY_W];
    assign key_hit    = slot_used && (rd_data_reg[KEY_W-1:0] == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        mod_start       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = {1'b0, key_reg};
        rd_addr         = pos_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_next = s_axis_tuser;
                    key_next  = s_axis_tdata[KEY_W-1:0];
                    size_next = live_size;
                    if (s_axis_tuser == KIND_INSERT || s_axis_tuser == KIND_DELETE ||
                        s_axis_tuser == KIND_SEARCH)
                    begin
                        mod_start  = 1'b1;
                        state_next = S_HASH;
                    end
                    else
                    begin
                        res_status_next = ST_ABSENT;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                // The first slot read is issued in the same cycle the remainder is ready.
                rd_addr = IDX_W'(mod_rem);
                if (mod_done)
                begin
                    pos_next   = IDX_W'(mod_rem);
                    n_next     = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // The read of the following slot goes out while this one is checked.
                rd_addr = pos_wrap;
                if (kind_reg == KIND_INSERT && !slot_used)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = {1'b1, key_reg};
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_W'(pos_reg);
                    state_next      = S_DONE;
                end
                else if (kind_reg != KIND_INSERT && key_hit)
                begin
                    mem_we          = (kind_reg == KIND_DELETE);
                    mem_wdata       = {1'b0, key_reg};
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_W'(pos_reg);
                    state_next      = S_DONE;
                end
                else if (probe_last)
                begin
                    res_status_next = (kind_reg == KIND_INSERT) ? ST_FULL : ST_ABSENT;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos_next = pos_wrap;
                    n_next   = n_reg + SIZE_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            table_size_reg <= SIZE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                table_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/lph_checker.sv */
// Port-level checker for the linear probing hash table, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module lph_checker
    import lph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] res_status;
    logic [SLOT_W-1:0]   res_slot;

    assign res_status = m_axis_tdata[STATUS_W-1:0];
    assign res_slot   = m_axis_tdata[STATUS_W+SLOT_W-1:STATUS_W];

    // A result held back downstream keeps its value.
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

    // Every transfer in is followed by busy work: the input is not ready in the next cycle.
    `ASSERT_CLK(a_busy_after_in, clk, rst_n,
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

    // Only defined status codes leave the block.
    `ASSERT_CLK(a_status_code, clk, rst_n,
        m_axis_tvalid |-> (res_status == ST_OK || res_status == ST_ABSENT ||
                           res_status == ST_FULL))

    // A failed operation reports slot zero.
    `ASSERT_NEVER(a_fail_slot, clk, rst_n,
        m_axis_tvalid && (res_status != ST_OK) && (res_slot != '0))

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (.*);

`default_nettype wire

/* test/lph_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the hash table: it keeps its own copy of the slots and checks each result.
module lph_scoreboard
    import lph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] key, [31] zero
    input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [1:0] status, [5:2] slot, [7:6] zero
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data,
    output int                    mismatch_count,
    output int                    results_seen,
    output int                    open_count,
    output int                    found_count,
    output int                    absent_count,
    output int                    full_count
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } outcome_t;

    logic [KEY_W-1:0]  mirror_key  [DEF_TABLE_DEPTH];
    logic              mirror_used [DEF_TABLE_DEPTH];
    logic [SIZE_W-1:0] mirror_size;
    outcome_t          awaited_outcomes [$];

    // Applies one operation to the mirrored table and returns what the block must report.
    function automatic outcome_t apply_table_op(input logic [KIND_W-1:0] kind,
                                                input logic [KEY_W-1:0] key);
        outcome_t    res;
        int unsigned span;
        int unsigned pos;
        int unsigned n;
        logic        done;
        if (mirror_size == 0)
            span = 1;
        else if (mirror_size > DEF_TABLE_DEPTH)
            span = DEF_TABLE_DEPTH;
        else
            span = 32'(mirror_size);
        res.status = ST_ABSENT;
        res.slot   = '0;
        done       = 1'b0;
        pos        = 32'(key) % span;
        if (kind == KIND_INSERT)
        begin
            res.status = ST_FULL;
            for (n = 0; n < span && !done; n++)
            begin
                if (!mirror_used[pos])
                begin
                    mirror_key[pos]  = key;
                    mirror_used[pos] = 1'b1;
                    res.status       = ST_OK;
                    res.slot         = pos[SLOT_W-1:0];
                    done             = 1'b1;
                end
                else
                    pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end
        else if (kind == KIND_DELETE || kind == KIND_SEARCH)
        begin
            for (n = 0; n < span && !done; n++)
            begin
                if (mirror_used[pos] && mirror_key[pos] == key)
                begin
                    res.status = ST_OK;
                    res.slot   = pos[SLOT_W-1:0];
                    done       = 1'b1;
                    if (kind == KIND_DELETE)
                        mirror_used[pos] = 1'b0;
                end
                else
                    pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        int       errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int i = 0; i < DEF_TABLE_DEPTH; i++)
                mirror_used[i] = 1'b0;
            mirror_size = SIZE_RESET;
            awaited_outcomes.delete();
            mismatch_count <= 0;
            results_seen   <= 0;
            open_count     <= 0;
            found_count    <= 0;
            absent_count   <= 0;
            full_count     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mirror_size = cfg_data;
            // The result is compared before this edge's item is queued, so a stray result
            // can never be matched against the prediction for an item taken at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[STATUS_W-1:0];
                got.slot   = m_axis_tdata[STATUS_W +: SLOT_W];
                results_seen <= results_seen + 1;
                if (awaited_outcomes.size() == 0)
                begin
                    errs = 1;
                    $display("%0t: result with nothing expected, got status %0d slot %0d",
                             $time, got.status, got.slot);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got.status !== want.status)
                    begin
                        errs++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.slot !== want.slot)
                    begin
                        errs++;
                        $display("%0t: slot mismatch, expected %0d, got %0d",
                                 $time, want.slot, got.slot);
                    end
                    case (want.status)
                        ST_OK:   found_count  <= found_count + 1;
                        ST_FULL: full_count   <= full_count + 1;
                        default: absent_count <= absent_count + 1;
                    endcase
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_outcomes.push_back(apply_table_op(s_axis_tuser,
                                                          s_axis_tdata[KEY_W-1:0]));
            mismatch_count <= mismatch_count + errs;
            open_count     <= awaited_outcomes.size();
        end
    end

endmodule

/* test/tb_linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// Testbench top for the hash table: clock, reset, stimulus, result-side stalls and verdict.
module tb_linear_probe_hash_table;
    import lph_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int PHASE_COUNT     = 12;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [30:0] key, [31] zero
    logic [KIND_W-1:0]     s_axis_tuser;   // [1:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [1:0] status, [5:2] slot, [7:6] zero
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     cfg_data;

    int mismatch_count;
    int results_seen;
    int open_count;
    int found_count;
    int absent_count;
    int full_count;

    logic             idle_on;
    int               items_sent;
    int               sizes_applied;
    int               hold_done;
    logic [KEY_W-1:0] key_pool [$];

    linear_probe_hash_table DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    lph_scoreboard u_scoreboard
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_seen   (results_seen),
        .open_count     (open_count),
        .found_count    (found_count),
        .absent_count   (absent_count),
        .full_count     (full_count)
    );

    initial
        clk = 1'b0;

    always
        #5 clk = ~clk;

    // Offers one item and returns at the edge where its transfer happens.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        while (idle_on && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Writes table_size once every outstanding result has come back.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sizes_applied++;
    endtask

    // Deletes and searches mostly use stored keys; small colliding keys and some wide ones.
    task automatic random_item();
        int          roll;
        int          idx;
        logic [31:0] rnd;
        logic [KEY_W-1:0] key;
        logic        from_pool;
        roll      = $urandom_range(0, 99);
        rnd       = $urandom();
        key       = ($urandom_range(0, 3) == 0) ? rnd[KEY_W-1:0]
                                                 : KEY_W'($urandom_range(0, 63));
        from_pool = key_pool.size() != 0 && $urandom_range(0, 99) < 80;
        if (roll < 42)
        begin
            send_item(KIND_INSERT, key);
            if (key_pool.size() < 48)
                key_pool.push_back(key);
        end
        else if (roll < 68)
        begin
            if (from_pool)
            begin
                idx = $urandom_range(0, key_pool.size() - 1);
                key = key_pool[idx];
                key_pool.delete(idx);
            end
            send_item(KIND_DELETE, key);
        end
        else if (roll < 96)
        begin
            if (from_pool)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item(KIND_SEARCH, key);
        end
        else
            send_item(KIND_UNUSED, key);
    endtask

    // Result side: random stalls, and one long hold-off once a few hundred results are in.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done     = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_done == 0 && results_seen >= 400)
            begin
                hold_done = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 36);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Run did not finish in time: %0d items sent, %0d results seen",
                 items_sent, results_seen);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int fixed_sizes [PHASE_COUNT];
        fixed_sizes   = '{1, 16, 0, 31, 2, 5, 17, 8, 3, 16, 12, 7};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_INSERT;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        idle_on       = 1'b1;
        items_sent    = 0;
        sizes_applied = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size of 16: empty table, collisions, wrap-around,
        // a deleted slot inside a probe chain, the unused kind and the widest key.
        send_item(KIND_SEARCH, 31'd0);
        send_item(KIND_DELETE, 31'd0);
        send_item(KIND_INSERT, 31'd0);
        send_item(KIND_INSERT, 31'd16);
        send_item(KIND_INSERT, 31'd32);
        send_item(KIND_INSERT, 31'h7FFF_FFFF);
        send_item(KIND_INSERT, 31'd31);
        send_item(KIND_SEARCH, 31'd31);
        send_item(KIND_SEARCH, 31'd32);
        send_item(KIND_DELETE, 31'd16);
        send_item(KIND_SEARCH, 31'd32);
        send_item(KIND_SEARCH, 31'd16);
        send_item(KIND_UNUSED, 31'd0);
        send_item(KIND_INSERT, 31'h2AAA_AAAA);
        send_item(KIND_INSERT, 31'h5555_5555);
        send_item(KIND_SEARCH, 31'h7FFF_FFFF);

        // Size zero acts as one slot, and slot 0 still holds key 0 from before.
        write_size(5'd0);
        send_item(KIND_INSERT, 31'd5);
        send_item(KIND_SEARCH, 31'd0);
        send_item(KIND_DELETE, 31'd0);
        send_item(KIND_INSERT, 31'd7);
        send_item(KIND_INSERT, 31'd9);

        // Oversized setting acts as the full depth; older entries become visible again.
        write_size(5'd31);
        send_item(KIND_SEARCH, 31'd31);
        send_item(KIND_SEARCH, 31'd7);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            idle_on <= (phase != 3);
            write_size(SIZE_W'(fixed_sizes[phase]));
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_item();
        end

        s_axis_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Sent %0d items over %0d size settings (0, 1, 16 and 31 among them), %0d results",
                 items_sent, sizes_applied, results_seen);
        $display("Outcomes: %0d done or found, %0d not present, %0d full; hold-off %0d cycles",
                 found_count, absent_count, full_count, hold_done);
        if (mismatch_count == 0 && open_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lph_pkg.sv
rtl/lph_mod.sv
rtl/linear_probe_hash_table.sv
rtl/lph_checker.sv
test/lph_checker.sv
test/tb_linear_probe_hash_table.sv
